### rtl/bafp_pkg.sv
// bafp_pkg: types, constants and the step-angle table for the bearing block
// depends on nothing; every other file takes names from here by scope
package bafp_pkg;

  // field widths
  localparam int unsigned CoordWidth    = 16;
  localparam int unsigned AngleFracBits = 6;
  localparam int unsigned BearingWidth  = 9 + AngleFracBits;
  localparam int unsigned DiffWidth     = CoordWidth + 1;

  // cordic datapath
  localparam int unsigned CordicSteps   = 16;
  localparam int unsigned MaxSteps      = 24;
  localparam int unsigned NormTop       = 40;
  localparam int unsigned AccFrac       = 20;
  localparam int unsigned VecWidth      = NormTop + 5;
  localparam int unsigned AccWidth      = AccFrac + 8;
  localparam int unsigned AngleWidth    = AccFrac + 7;
  localparam int unsigned TotalWidth    = AccFrac + 9;

  // queue between front and back
  localparam int unsigned QueueDepth    = 2;

  typedef struct packed {
    logic signed [CoordWidth-1:0] source_x;
    logic signed [CoordWidth-1:0] source_y;
    logic signed [CoordWidth-1:0] target_x;
    logic signed [CoordWidth-1:0] target_y;
  } bafp_in_t;

  typedef struct packed {
    logic [BearingWidth-1:0] bearing;
    logic                    degenerate;
  } bafp_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [DiffWidth-1:0] ax;
    logic [DiffWidth-1:0] ay;
    logic                 right;
    logic                 above;
    logic                 ax_zero;
    logic                 ay_zero;
  } bafp_cls_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [AccWidth-1:0] step_angle(input int unsigned i);
    logic signed [AccWidth-1:0] a;
    unique case (i)
      0:  a = AccWidth'(47185920);
      1:  a = AccWidth'(27855475);
      2:  a = AccWidth'(14718068);
      3:  a = AccWidth'(7471121);
      4:  a = AccWidth'(3750058);
      5:  a = AccWidth'(1876857);
      6:  a = AccWidth'(938658);
      7:  a = AccWidth'(469357);
      8:  a = AccWidth'(234682);
      9:  a = AccWidth'(117342);
      10: a = AccWidth'(58671);
      11: a = AccWidth'(29335);
      12: a = AccWidth'(14668);
      13: a = AccWidth'(7334);
      14: a = AccWidth'(3667);
      15: a = AccWidth'(1833);
      16: a = AccWidth'(917);
      17: a = AccWidth'(458);
      18: a = AccWidth'(229);
      19: a = AccWidth'(115);
      20: a = AccWidth'(57);
      21: a = AccWidth'(29);
      22: a = AccWidth'(14);
      23: a = AccWidth'(7);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/bafp_front.sv
// bafp_front: accepts point pairs, forms the differences and classifies them
// depends on bafp_pkg
module bafp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bafp_pkg::bafp_in_t   in_data_i,
  output logic                 cls_valid_o,
  input  logic                 cls_ready_i,
  output bafp_pkg::bafp_cls_t  cls_data_o
);

  localparam int unsigned DW = bafp_pkg::DiffWidth;

  logic                 vld_q;
  bafp_pkg::bafp_cls_t  cls_q;
  bafp_pkg::bafp_cls_t  cls_d;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic                 take;

  assign in_ready_o = !vld_q || cls_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    dx = DW'(in_data_i.target_x) - DW'(in_data_i.source_x);
    dy = DW'(in_data_i.target_y) - DW'(in_data_i.source_y);
    cls_d.ax      = dx[DW-1] ? -dx : dx;
    cls_d.ay      = dy[DW-1] ? -dy : dy;
    cls_d.right   = !dx[DW-1] && (dx != '0);
    cls_d.above   = dy[DW-1];
    cls_d.ax_zero = (dx == '0);
    cls_d.ay_zero = (dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q <= cls_d;
    end
  end

  assign cls_valid_o = vld_q;
  assign cls_data_o  = cls_q;

endmodule

### rtl/bafp_queue.sv
// bafp_queue: short register queue between the front and back parts
// depends on bafp_pkg
module bafp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_ready_o,
  input  bafp_pkg::bafp_cls_t  wr_data_i,
  output logic                 rd_valid_o,
  input  logic                 rd_ready_i,
  output bafp_pkg::bafp_cls_t  rd_data_o
);

  localparam int unsigned Depth = bafp_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bafp_pkg::bafp_cls_t mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d;
  logic [PtrW-1:0]     rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push;
  logic                pop;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/bafp_back.sv
// bafp_back: normalize, pipelined vectoring cordic, quadrant placement, rounding
// depends on bafp_pkg
module bafp_back #(
  parameter int unsigned CORDIC_STEPS = bafp_pkg::CordicSteps
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cls_valid_i,
  output logic                 cls_ready_o,
  input  bafp_pkg::bafp_cls_t  cls_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bafp_pkg::bafp_out_t  out_data_o
);

  localparam int unsigned DW    = bafp_pkg::DiffWidth;
  localparam int unsigned XW    = bafp_pkg::VecWidth;
  localparam int unsigned ZW    = bafp_pkg::AccWidth;
  localparam int unsigned AW    = bafp_pkg::AngleWidth;
  localparam int unsigned TW    = bafp_pkg::TotalWidth;
  localparam int unsigned BW    = bafp_pkg::BearingWidth;
  localparam int unsigned MsbW  = $clog2(DW);
  localparam int unsigned ShW   = $clog2(bafp_pkg::NormTop + 1);
  localparam int unsigned Steps = (CORDIC_STEPS > bafp_pkg::MaxSteps) ?
                                  bafp_pkg::MaxSteps : CORDIC_STEPS;
  localparam int unsigned RoundShift = bafp_pkg::AccFrac - bafp_pkg::AngleFracBits;
  localparam logic [TW-1:0] RoundHalf = (RoundShift == 0) ? '0 :
                                        (TW'(1) << (RoundShift - 1));
  localparam logic [AW-1:0] Ninety   = AW'(90) << bafp_pkg::AccFrac;
  localparam logic [TW-1:0] Deg90    = TW'(90) << bafp_pkg::AccFrac;
  localparam logic [TW-1:0] Deg270   = TW'(270) << bafp_pkg::AccFrac;
  localparam logic [BW-1:0] FullTurn = BW'(360) << bafp_pkg::AngleFracBits;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 right;
    logic                 above;
    logic                 ax_zero;
    logic                 ay_zero;
  } cord_t;

  typedef struct packed {
    logic [TW-1:0] total;
    logic          degenerate;
  } place_t;

  logic            en;
  logic            nv_q;
  cord_t           n_q, n_d;
  logic [Steps-1:0] cv_q;
  cord_t           c_q [Steps];
  logic            pv_q;
  place_t          p_q, p_d;
  logic            ov_q;
  bafp_pkg::bafp_out_t o_q, o_d;

  logic [DW-1:0]   m;
  logic [MsbW-1:0] msb;
  logic [ShW-1:0]  sh;
  logic [AW-1:0]   a_clamp;
  logic [AW-1:0]   a_sel;
  logic [TW-1:0]   r_sum;
  logic [BW-1:0]   r;

  // whole pipeline moves together while the output can drain
  assign en          = !ov_q || out_ready_i;
  assign cls_ready_o = en;

  // normalize: scale the larger magnitude up to the fixed top bit
  always_comb begin
    m   = (cls_data_i.ax > cls_data_i.ay) ? cls_data_i.ax : cls_data_i.ay;
    msb = '0;
    for (int b = 0; b < DW; b++) begin
      if (m[b]) begin
        msb = MsbW'(b);
      end
    end
    sh          = ShW'(bafp_pkg::NormTop) - ShW'(msb);
    n_d.x       = XW'(cls_data_i.ax) << sh;
    n_d.y       = XW'(cls_data_i.ay) << sh;
    n_d.z       = '0;
    n_d.right   = cls_data_i.right;
    n_d.above   = cls_data_i.above;
    n_d.ax_zero = cls_data_i.ax_zero;
    n_d.ay_zero = cls_data_i.ay_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else if (en) begin
      nv_q <= cls_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q <= n_d;
    end
  end

  // one cordic rotation per stage
  for (genvar k = 0; k < Steps; k++) begin : g_step
    cord_t c_in;
    logic  v_in;
    cord_t c_d;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    if (k == 0) begin : g_first
      assign c_in = n_q;
      assign v_in = nv_q;
    end else begin : g_rest
      assign c_in = c_q[k-1];
      assign v_in = cv_q[k-1];
    end

    always_comb begin
      xs  = c_in.x >>> k;
      ys  = c_in.y >>> k;
      c_d = c_in;
      if (!c_in.y[XW-1]) begin
        c_d.x = c_in.x + ys;
        c_d.y = c_in.y - xs;
        c_d.z = c_in.z + bafp_pkg::step_angle(k);
      end else begin
        c_d.x = c_in.x - ys;
        c_d.y = c_in.y + xs;
        c_d.z = c_in.z - bafp_pkg::step_angle(k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k] <= 1'b0;
      end else if (en) begin
        cv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        c_q[k] <= c_d;
      end
    end
  end

  // clamp the base angle and place it by quadrant
  always_comb begin
    if (c_q[Steps-1].z[ZW-1]) begin
      a_clamp = '0;
    end else if (c_q[Steps-1].z > $signed({1'b0, Ninety})) begin
      a_clamp = Ninety;
    end else begin
      a_clamp = c_q[Steps-1].z[AW-1:0];
    end
    priority if (c_q[Steps-1].ax_zero) begin
      a_sel = Ninety;
    end else if (c_q[Steps-1].ay_zero) begin
      a_sel = '0;
    end else begin
      a_sel = a_clamp;
    end
    unique case ({c_q[Steps-1].right, c_q[Steps-1].above})
      2'b11:   p_d.total = Deg90 - TW'(a_sel);
      2'b10:   p_d.total = Deg90 + TW'(a_sel);
      2'b01:   p_d.total = Deg270 + TW'(a_sel);
      default: p_d.total = Deg270 - TW'(a_sel);
    endcase
    p_d.degenerate = c_q[Steps-1].ax_zero && c_q[Steps-1].ay_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= cv_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= p_d;
    end
  end

  // round half up to the output unit, wrap a full turn and degenerate results to zero
  always_comb begin
    r_sum = p_q.total + RoundHalf;
    r     = BW'(r_sum >> RoundShift);
    o_d.degenerate = p_q.degenerate;
    if (p_q.degenerate || (r == FullTurn)) begin
      o_d.bearing = '0;
    end else begin
      o_d.bearing = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_q <= o_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = o_q;

endmodule

### rtl/bearing_angle_from_two_points_top.sv
// bearing_angle_from_two_points_top: compass bearing between two screen points
// depends on bafp_pkg, bafp_front, bafp_queue, bafp_back
//
// Takes a source and a target point (y grows downward) and returns the clockwise
// bearing from source to target, 0 pointing up and 90 pointing right, in units
// of 1/64 degree (0 .. 23039). Coincident points set degenerate and give 0.
// Throughput is one request per cycle while the result channel does not stall. The
// back part is a pipelined vectoring cordic with one register stage per rotation.
// A front stage classifies each request, a two-entry queue decouples it from the
// back pipeline, and the back pipeline advances whenever its output register is
// empty or being taken, so each side can stall without stopping the other at
// once.
module bearing_angle_from_two_points_top #(
  parameter int unsigned CORDIC_STEPS = bafp_pkg::CordicSteps
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bafp_pkg::bafp_in_t   in_data_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bafp_pkg::bafp_out_t  out_data_o
);

  // front to queue
  logic                cls_valid;
  logic                cls_ready;
  bafp_pkg::bafp_cls_t cls_data;

  // queue to back
  logic                q_valid;
  logic                q_ready;
  bafp_pkg::bafp_cls_t q_data;

  // differences, magnitudes and quadrant flags
  bafp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cls_valid_o (cls_valid),
    .cls_ready_i (cls_ready),
    .cls_data_o  (cls_data)
  );

  // short queue so front and back stall independently
  bafp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cls_valid),
    .wr_ready_o (cls_ready),
    .wr_data_i  (cls_data),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  // normalize, cordic, placement and rounding
  bafp_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (q_valid),
    .cls_ready_o (q_ready),
    .cls_data_i  (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/bafp_checker.sv
// bafp_port_checker: port-level checks for the bearing block, bound to the top level
// depends on bafp_pkg and bearing_angle_from_two_points_top
module bafp_port_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bafp_pkg::bafp_out_t out_data_o
);

  localparam logic [bafp_pkg::BearingWidth-1:0] FullTurn =
    bafp_pkg::BearingWidth'(360) << bafp_pkg::AngleFracBits;

  logic [7:0] pend_q;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid_i && in_ready_o;
  assign out_take = out_valid_o && out_ready_i;

  // requests accepted whose results are not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_take && !out_take) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_take && !in_take) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_bearing_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bearing < FullTurn)
    else $error("bearing not wrapped below a full turn");

  a_degenerate_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.bearing == '0)
    else $error("degenerate result with nonzero bearing");

  a_no_invented : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without a pending request");

endmodule

bind bearing_angle_from_two_points_top bafp_port_checker u_bafp_port_checker (.*);
